### hdl/assert_macros.svh
// Assertion macros shared by the smoother RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a condition is followed by a property in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### hdl/vls_pkg.sv
// Shared types and constants of the volume Laplacian smoother.
// No dependencies; imported by the sweep engine and the top level.
`default_nettype none

package vls_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_RUN   = 2'd2;

   localparam logic [2:0] CSR_SIZE_I      = 3'd0;
   localparam logic [2:0] CSR_SIZE_J      = 3'd1;
   localparam logic [2:0] CSR_SIZE_K      = 3'd2;
   localparam logic [2:0] CSR_SWEEP_COUNT = 3'd3;
   localparam logic [2:0] CSR_KEEP_MODE   = 3'd4;

   localparam logic [1:0] KEEP_NONE = 2'd0;
   localparam logic [1:0] KEEP_HIGH = 2'd1;
   localparam logic [1:0] KEEP_LOW  = 2'd2;

   localparam logic [15:0] ONE_FIXED       = 16'd32768;
   localparam logic [15:0] KEEP_HIGH_ABOVE = 16'd32735;
   localparam logic [15:0] KEEP_LOW_BELOW  = 16'd33;

   // floor(x / 6) equals (x * DIV6_MULT) >> DIV6_SHIFT for every x below 2^19.
   localparam int          ACC_W      = 19;
   localparam logic [17:0] DIV6_MULT  = 18'd174763;
   localparam int          DIV6_SHIFT = 20;

   localparam logic [3:0] PH_CENTER = 4'd0;
   localparam logic [3:0] PH_KEEP   = 4'd1;
   localparam logic [3:0] PH_I_UP   = 4'd1;
   localparam logic [3:0] PH_I_DN   = 4'd2;
   localparam logic [3:0] PH_J_UP   = 4'd3;
   localparam logic [3:0] PH_J_DN   = 4'd4;
   localparam logic [3:0] PH_K_UP   = 4'd5;
   localparam logic [3:0] PH_K_DN   = 4'd6;
   localparam logic [3:0] PH_SUM    = 4'd7;
   localparam logic [3:0] PH_WRITE  = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } eng_state_type;

   typedef struct packed {
      logic [5:0] size_i;
      logic [5:0] size_j;
      logic [5:0] size_k;
      logic [7:0] sweep_count;
      logic [1:0] keep_mode;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_status_type;

endpackage

`default_nettype wire

### hdl/vls_volume_mem.sv
// Voxel store: one write port and one read port with registered read data.
// Depends on nothing but its address width parameter.
`default_nettype none

module vls_volume_mem #(
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem_ff [2**ADDR_W];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/vls_sweep_engine.sv
// Smoothing sequencer: walks the interior voxels, reads center and six neighbors,
// divides the six neighbors' sum by six and writes back. Uses vls_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vls_sweep_engine
   import vls_pkg::*;
#(
   parameter int MAX_DIM = 32,
   localparam int DIM_BITS = $clog2(MAX_DIM),
   localparam int ADDR_W = 3 * DIM_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cfg_type           cfg,
   output eng_status_type    status,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [15:0]       rd_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [15:0]       wr_data
);

   localparam int SZW = DIM_BITS + 1;
   localparam logic [DIM_BITS-1:0] IDX_ONE = DIM_BITS'(1);

   function automatic logic [SZW-1:0] clamp_size(input logic [5:0] size);
      logic [8:0] ext;
      logic [8:0] lim;
      ext = {3'b000, size};
      lim = 9'(MAX_DIM);
      clamp_size = (ext > lim) ? lim[SZW-1:0] : ext[SZW-1:0];
   endfunction

   eng_state_type       state_ff, state_in;
   logic [DIM_BITS-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [7:0]          s_ff, s_in;
   logic [3:0]          ph_ff, ph_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SZW-1:0]      n_i, n_j, n_k;
   logic [SZW-1:0]      last_i, last_j, last_k;
   logic                degenerate, keep, step;
   logic                wrap_i, wrap_j, wrap_k;
   logic [ACC_W+17:0]   prod;

   assign n_i = clamp_size(cfg.size_i);
   assign n_j = clamp_size(cfg.size_j);
   assign n_k = clamp_size(cfg.size_k);
   assign last_i = n_i - SZW'(2);
   assign last_j = n_j - SZW'(2);
   assign last_k = n_k - SZW'(2);
   assign degenerate = (n_i < SZW'(3)) || (n_j < SZW'(3)) || (n_k < SZW'(3))
                       || (cfg.sweep_count == 8'd0);
   assign wrap_i = ({1'b0, i_ff} == last_i);
   assign wrap_j = ({1'b0, j_ff} == last_j);
   assign wrap_k = ({1'b0, k_ff} == last_k);
   assign keep = ((cfg.keep_mode == KEEP_HIGH) && (rd_data > KEEP_HIGH_ABOVE))
              || ((cfg.keep_mode == KEEP_LOW) && (rd_data < KEEP_LOW_BELOW));

   assign prod = acc_ff * DIV6_MULT;
   assign wr_addr = {i_ff, j_ff, k_ff};
   assign wr_data = prod[DIV6_SHIFT +: 16];

   always_comb begin
      case (ph_ff)
         PH_I_UP: rd_addr = {i_ff + IDX_ONE, j_ff, k_ff};
         PH_I_DN: rd_addr = {i_ff - IDX_ONE, j_ff, k_ff};
         PH_J_UP: rd_addr = {i_ff, j_ff + IDX_ONE, k_ff};
         PH_J_DN: rd_addr = {i_ff, j_ff - IDX_ONE, k_ff};
         PH_K_UP: rd_addr = {i_ff, j_ff, k_ff + IDX_ONE};
         PH_K_DN: rd_addr = {i_ff, j_ff, k_ff - IDX_ONE};
         default: rd_addr = {i_ff, j_ff, k_ff};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      s_in = s_ff;
      ph_in = ph_ff;
      acc_in = acc_ff;
      wr_en = 1'b0;
      step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in = IDX_ONE;
               j_in = IDX_ONE;
               k_in = IDX_ONE;
               s_in = 8'd0;
               ph_in = PH_CENTER;
               state_in = degenerate ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (ph_ff == PH_KEEP) begin
               acc_in = '0;
               if (keep) begin
                  step = 1'b1;
               end else begin
                  ph_in = ph_ff + 4'd1;
               end
            end else if (ph_ff == PH_WRITE) begin
               wr_en = 1'b1;
               step = 1'b1;
            end else begin
               if (ph_ff >= PH_I_DN) begin
                  acc_in = acc_ff + {3'b000, rd_data};
               end
               ph_in = ph_ff + 4'd1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (step) begin
         ph_in = PH_CENTER;
         k_in = wrap_k ? IDX_ONE : k_ff + IDX_ONE;
         if (wrap_k) begin
            j_in = wrap_j ? IDX_ONE : j_ff + IDX_ONE;
            if (wrap_j) begin
               i_in = wrap_i ? IDX_ONE : i_ff + IDX_ONE;
               if (wrap_i) begin
                  s_in = s_ff + 8'd1;
                  if (s_ff + 8'd1 == cfg.sweep_count) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      s_ff <= s_in;
      ph_ff <= ph_in;
      acc_ff <= acc_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   `ASSERT_NEXT(a_start_runs, start && state_ff == ST_IDLE, state_ff != ST_IDLE, "Start ignored")
   `ASSERT_CLK(a_interior, wr_en |-> (i_ff != '0 && j_ff != '0 && k_ff != '0), "Boundary write")
   `ASSERT_CLK(a_phase, state_ff == ST_RUN |-> ph_ff <= PH_WRITE, "Phase out of range")

endmodule

`default_nettype wire

### hdl/volume_laplacian_smoother.sv
// Reads and writes are accepted one word per cycle while busy is low; the result is registered
// and appears in the cycle after acceptance. A run holds busy high over all sweeps, since the
// single read port fetches the center and six neighbors of each smoothed voxel in turn.
// The result word of a run is strobed in the first cycle with busy low; the receiver cannot stall.
// Reset restores control and configuration defaults; voxel contents stay undefined until written.
// Top level; uses vls_pkg, vls_volume_mem, vls_sweep_engine and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module volume_laplacian_smoother
   import vls_pkg::*;
#(
   parameter int MAX_DIM = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [4:0]  req_coord_i,
   input  logic [4:0]  req_coord_j,
   input  logic [4:0]  req_coord_k,
   input  logic [15:0] req_write_value,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_read_value,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   localparam int DIM_BITS = $clog2(MAX_DIM);
   localparam int ADDR_W = 3 * DIM_BITS;

   cfg_type             cfg_ff;
   eng_status_type      eng_status;
   logic                accept, in_range, host_write;
   logic [8:0]          ci_ext, cj_ext, ck_ext;
   logic [ADDR_W-1:0]   host_addr, eng_rd_addr, eng_wr_addr, rd_addr, wr_addr;
   logic [15:0]         eng_wr_data, wr_data, rd_data, sat_value;
   logic                eng_wr_en, wr_en;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic                rsp_sel_ff, rsp_sel_in;

   assign busy = eng_status.busy;
   assign accept = start && !busy;

   assign ci_ext = {4'b0000, req_coord_i};
   assign cj_ext = {4'b0000, req_coord_j};
   assign ck_ext = {4'b0000, req_coord_k};
   assign in_range = (ci_ext < 9'(MAX_DIM)) && (cj_ext < 9'(MAX_DIM))
                     && (ck_ext < 9'(MAX_DIM));
   assign host_addr = {ci_ext[DIM_BITS-1:0], cj_ext[DIM_BITS-1:0], ck_ext[DIM_BITS-1:0]};
   assign sat_value = (req_write_value > ONE_FIXED) ? ONE_FIXED : req_write_value;
   assign host_write = accept && (req_operation == OP_WRITE) && in_range;

   assign wr_en = busy ? eng_wr_en : host_write;
   assign wr_addr = busy ? eng_wr_addr : host_addr;
   assign wr_data = busy ? eng_wr_data : sat_value;
   assign rd_addr = busy ? eng_rd_addr : host_addr;

   vls_volume_mem #(
      .ADDR_W(ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vls_sweep_engine #(
      .MAX_DIM(MAX_DIM)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_operation == OP_RUN)),
      .cfg     (cfg_ff),
      .status  (eng_status),
      .rd_addr (eng_rd_addr),
      .rd_data (rd_data),
      .wr_en   (eng_wr_en),
      .wr_addr (eng_wr_addr),
      .wr_data (eng_wr_data)
   );

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_kind_in = KIND_WRITE;
      rsp_sel_in = 1'b0;
      if (eng_status.done) begin
         rsp_strobe_in = 1'b1;
         rsp_kind_in = KIND_RUN;
      end else if (accept && (req_operation != OP_RUN)) begin
         rsp_strobe_in = 1'b1;
         if (req_operation == OP_READ) begin
            rsp_kind_in = KIND_READ;
            rsp_sel_in = in_range;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         cfg_ff.size_i <= 6'd32;
         cfg_ff.size_j <= 6'd32;
         cfg_ff.size_k <= 6'd32;
         cfg_ff.sweep_count <= 8'd0;
         cfg_ff.keep_mode <= KEEP_NONE;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SIZE_I:      cfg_ff.size_i <= csr_write_data[5:0];
               CSR_SIZE_J:      cfg_ff.size_j <= csr_write_data[5:0];
               CSR_SIZE_K:      cfg_ff.size_k <= csr_write_data[5:0];
               CSR_SWEEP_COUNT: cfg_ff.sweep_count <= csr_write_data;
               CSR_KEEP_MODE:   cfg_ff.keep_mode <= csr_write_data[1:0];
               default: begin
               end
            endcase
         end
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_sel_ff <= rsp_sel_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_read_value = rsp_sel_ff ? rd_data : 16'd0;

   `ASSERT_NEXT(a_item_resp, accept && req_operation != OP_RUN, rsp_strobe, "Missing word")
   `ASSERT_NEXT(a_run_resp, eng_status.done,
      rsp_strobe && rsp_result_kind == KIND_RUN, "No run word")
   `ASSERT_CLK(a_zero_value,
      (rsp_strobe && rsp_result_kind != KIND_READ) |-> rsp_read_value == 16'd0, "Nonzero value")

endmodule

`default_nettype wire
